### src/tbb_pkg.sv
`timescale 1ns / 1ps

package tbb_pkg;

  // fixed point format of every field
  localparam int TBB_FRAC_BITS = 16;
  localparam int TBB_WORD_W    = 32;

  // exact product and the widened sum of offset plus three terms
  localparam int TBB_PROD_W = 2 * TBB_WORD_W;
  localparam int TBB_SUM_W  = TBB_PROD_W + 2;

  // number of lanes, one per local axis
  localparam int TBB_LANES = 3;

  // configuration register indexes
  localparam int TBB_CFG_IDX_W = 3;
  typedef enum logic [TBB_CFG_IDX_W-1:0] {
    REG_BOX_LOW_X  = 3'd0,
    REG_BOX_LOW_Y  = 3'd1,
    REG_BOX_LOW_Z  = 3'd2,
    REG_BOX_HIGH_X = 3'd3,
    REG_BOX_HIGH_Y = 3'd4,
    REG_BOX_HIGH_Z = 3'd5
  } cfg_reg_t;

  // load enables of the four pipeline stages
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
    logic s4;
  } stage_en_t;

endpackage

### src/tbb_lane.sv
`timescale 1ns / 1ps

module tbb_lane import tbb_pkg::*; #(
  parameter int FRAC_BITS = TBB_FRAC_BITS
) (
  input  logic                          clk,
  input  stage_en_t                     en,
  input  logic signed [TBB_WORD_W-1:0]  coef,
  input  logic signed [TBB_WORD_W-1:0]  box_low,
  input  logic signed [TBB_WORD_W-1:0]  box_high,
  output logic signed [TBB_PROD_W-1:0]  term_min,
  output logic signed [TBB_PROD_W-1:0]  term_max
);

  logic signed [TBB_PROD_W-1:0] prod_low;
  logic signed [TBB_PROD_W-1:0] prod_high;
  logic signed [TBB_PROD_W-1:0] prod_low_next;
  logic signed [TBB_PROD_W-1:0] prod_high_next;
  logic signed [TBB_PROD_W-1:0] shift_low;
  logic signed [TBB_PROD_W-1:0] shift_high;

  // exact 32x32 signed products
  always_comb begin
    prod_low_next  = TBB_PROD_W'(coef) * TBB_PROD_W'(box_low);
    prod_high_next = TBB_PROD_W'(coef) * TBB_PROD_W'(box_high);
  end

  // arithmetic shift rounds toward minus infinity
  assign shift_low  = prod_low >>> FRAC_BITS;
  assign shift_high = prod_high >>> FRAC_BITS;

  always_ff @(posedge clk) begin
    if (en.s1) begin
      prod_low  <= prod_low_next;
      prod_high <= prod_high_next;
    end
    if (en.s2) begin
      if (shift_low < shift_high) begin
        term_min <= shift_low;
        term_max <= shift_high;
      end else begin
        term_min <= shift_high;
        term_max <= shift_low;
      end
    end
  end

endmodule

### src/tbb_merge.sv
`timescale 1ns / 1ps

module tbb_merge import tbb_pkg::*; (
  input  logic                          clk,
  input  stage_en_t                     en,
  input  logic signed [TBB_PROD_W-1:0]  term_min [TBB_LANES],
  input  logic signed [TBB_PROD_W-1:0]  term_max [TBB_LANES],
  input  logic signed [TBB_WORD_W-1:0]  offset,
  output logic signed [TBB_WORD_W-1:0]  axis_low,
  output logic signed [TBB_WORD_W-1:0]  axis_high
);

  localparam logic signed [TBB_SUM_W-1:0] SAT_MAX = TBB_SUM_W'(32'sh7fffffff);
  localparam logic signed [TBB_SUM_W-1:0] SAT_MIN = TBB_SUM_W'(32'sh80000000);

  logic signed [TBB_SUM_W-1:0] low_a;
  logic signed [TBB_SUM_W-1:0] low_b;
  logic signed [TBB_SUM_W-1:0] high_a;
  logic signed [TBB_SUM_W-1:0] high_b;
  logic signed [TBB_SUM_W-1:0] low_total;
  logic signed [TBB_SUM_W-1:0] high_total;

  assign low_total  = low_a + low_b;
  assign high_total = high_a + high_b;

  function automatic logic signed [TBB_WORD_W-1:0] clamp_word(
    input logic signed [TBB_SUM_W-1:0] v
  );
    logic signed [TBB_WORD_W-1:0] r;
    if (v > SAT_MAX) begin
      r = SAT_MAX[TBB_WORD_W-1:0];
    end else if (v < SAT_MIN) begin
      r = SAT_MIN[TBB_WORD_W-1:0];
    end else begin
      r = v[TBB_WORD_W-1:0];
    end
    return r;
  endfunction

  always_ff @(posedge clk) begin
    // pairwise partial sums
    if (en.s3) begin
      low_a  <= TBB_SUM_W'(term_min[0]) + TBB_SUM_W'(term_min[1]);
      low_b  <= TBB_SUM_W'(term_min[2]) + TBB_SUM_W'(offset);
      high_a <= TBB_SUM_W'(term_max[0]) + TBB_SUM_W'(term_max[1]);
      high_b <= TBB_SUM_W'(term_max[2]) + TBB_SUM_W'(offset);
    end
    // final sum and clamp into the output word
    if (en.s4) begin
      axis_low  <= clamp_word(low_total);
      axis_high <= clamp_word(high_total);
    end
  end

endmodule

### src/transformed_box_bounds.sv
`timescale 1ns / 1ps

// transformed box bounds: one axis of the world-space bounding box of a local
// axis-aligned box after an affine transform. the six box corner registers are
// written over the cfg port (index 0..2 low x/y/z, 3..5 high x/y/z, others
// ignored); the user must write them only while the block is idle, which the
// block itself does not enforce. each row word carries coef_x/y/z and
// row_offset; the result word gives axis_low/axis_high, the least and greatest
// value of the row over all eight corners, saturated to signed Q16.16. three
// axis lanes each form two exact 32x32 products, floor them by FRAC_BITS and
// pick min and max; a merge stage adds the offset and clamps. the pipeline is
// four stages deep (products, min/max, partial sums, clamped sum). a stalled
// result only holds the last stage; bubbles further up keep collapsing, so one
// row is still accepted every cycle until all four stages are full.
module transformed_box_bounds import tbb_pkg::*; #(
  parameter int FRAC_BITS = TBB_FRAC_BITS
) (
  input  logic                           clk,
  input  logic                           rst,
  // configuration
  input  logic                           cfg_write,
  input  logic [TBB_CFG_IDX_W-1:0]       cfg_index,
  input  logic [TBB_WORD_W-1:0]          cfg_data,
  // row words
  input  logic                           row_valid,
  output logic                           row_stall,
  input  logic signed [TBB_WORD_W-1:0]   coef_x,
  input  logic signed [TBB_WORD_W-1:0]   coef_y,
  input  logic signed [TBB_WORD_W-1:0]   coef_z,
  input  logic signed [TBB_WORD_W-1:0]   row_offset,
  // bounds words
  output logic                           bounds_valid,
  input  logic                           bounds_stall,
  output logic signed [TBB_WORD_W-1:0]   axis_low,
  output logic signed [TBB_WORD_W-1:0]   axis_high
);

  // box corner registers, one entry per lane
  logic signed [TBB_WORD_W-1:0] box_low  [TBB_LANES];
  logic signed [TBB_WORD_W-1:0] box_high [TBB_LANES];

  // stage valid bits; the last one is bounds_valid
  logic v1;
  logic v2;
  logic v3;

  // offset travels beside the lanes to the merge stage
  logic signed [TBB_WORD_W-1:0] offset_s1;
  logic signed [TBB_WORD_W-1:0] offset_s2;

  // a stage is ready when empty or when its word moves on this cycle
  logic      leave4;
  logic      rdy1;
  logic      rdy2;
  logic      rdy3;
  logic      rdy4;
  stage_en_t en;

  logic signed [TBB_WORD_W-1:0] coef     [TBB_LANES];
  logic signed [TBB_PROD_W-1:0] term_min [TBB_LANES];
  logic signed [TBB_PROD_W-1:0] term_max [TBB_LANES];

  assign leave4 = bounds_valid && !bounds_stall;
  assign rdy4   = !bounds_valid || leave4;
  assign rdy3   = !v3 || rdy4;
  assign rdy2   = !v2 || rdy3;
  assign rdy1   = !v1 || rdy2;

  assign row_stall = !rdy1;

  always_comb begin
    en.s1 = row_valid && rdy1;
    en.s2 = v1 && rdy2;
    en.s3 = v2 && rdy3;
    en.s4 = v3 && rdy4;
  end

  // pipeline control
  always_ff @(posedge clk) begin
    if (rst) begin
      v1           <= 1'b0;
      v2           <= 1'b0;
      v3           <= 1'b0;
      bounds_valid <= 1'b0;
    end else begin
      v1           <= en.s1 || (v1 && !en.s2);
      v2           <= en.s2 || (v2 && !en.s3);
      v3           <= en.s3 || (v3 && !en.s4);
      bounds_valid <= en.s4 || (bounds_valid && !leave4);
    end
  end

  // offset delay line, matched to the two lane stages
  always_ff @(posedge clk) begin
    if (en.s1) begin
      offset_s1 <= row_offset;
    end
    if (en.s2) begin
      offset_s2 <= offset_s1;
    end
  end

  // configuration writes; unknown indexes fall through
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < TBB_LANES; i++) begin
        box_low[i]  <= '0;
        box_high[i] <= '0;
      end
    end else if (cfg_write) begin
      case (cfg_reg_t'(cfg_index))
        REG_BOX_LOW_X:  box_low[0]  <= cfg_data;
        REG_BOX_LOW_Y:  box_low[1]  <= cfg_data;
        REG_BOX_LOW_Z:  box_low[2]  <= cfg_data;
        REG_BOX_HIGH_X: box_high[0] <= cfg_data;
        REG_BOX_HIGH_Y: box_high[1] <= cfg_data;
        REG_BOX_HIGH_Z: box_high[2] <= cfg_data;
        default: ;
      endcase
    end
  end

  assign coef[0] = coef_x;
  assign coef[1] = coef_y;
  assign coef[2] = coef_z;

  // one lane per local axis
  for (genvar g = 0; g < TBB_LANES; g++) begin : g_lane
    tbb_lane #(
      .FRAC_BITS (FRAC_BITS)
    ) u_lane (
      .clk      (clk),
      .en       (en),
      .coef     (coef[g]),
      .box_low  (box_low[g]),
      .box_high (box_high[g]),
      .term_min (term_min[g]),
      .term_max (term_max[g])
    );
  end

  // offset plus lane terms, then saturate
  tbb_merge u_merge (
    .clk       (clk),
    .en        (en),
    .term_min  (term_min),
    .term_max  (term_max),
    .offset    (offset_s2),
    .axis_low  (axis_low),
    .axis_high (axis_high)
  );

  // the low bound can never pass the high bound
  assert property (@(posedge clk) disable iff (rst)
    bounds_valid |-> (axis_low <= axis_high))
    else $error("axis_low above axis_high");

  // rows are refused only when every stage holds a word
  assert property (@(posedge clk) disable iff (rst)
    row_stall |-> (v1 && v2 && v3 && bounds_valid))
    else $error("row stalled with a bubble in the pipeline");

  // an accepted row always lands in the first stage
  assert property (@(posedge clk) disable iff (rst)
    (row_valid && !row_stall) |=> v1)
    else $error("accepted row lost at stage one");

  // a held result is neither dropped nor changed
  assert property (@(posedge clk) disable iff (rst)
    (bounds_valid && bounds_stall) |=>
      (bounds_valid && $stable(axis_low) && $stable(axis_high)))
    else $error("held result dropped or changed");

  // reset empties the pipeline
  assert property (@(posedge clk)
    rst |=> (!v1 && !v2 && !v3 && !bounds_valid))
    else $error("pipeline not empty after reset");

endmodule
